FILE: rtl/ole_pkg.sv
// Shared constants, command and status codes, and control structs for the
// ordered list engine. No dependencies.
`default_nettype none

package ole_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CmdW     = 3;
  localparam int PosW     = 5;
  localparam int DataW    = 32;
  localparam int StatW    = 3;
  localparam int FoundW   = 4;
  localparam int CntW     = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_TAIL   = 3'd0,
    CMD_ADD_HEAD   = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_REMOVE_TAIL = 3'd3,
    CMD_REMOVE_HEAD = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture input beat
    logic exec;  // apply captured command
  } dp_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ole_ctrl.sv
// Handshake controller for the ordered list engine: idle / execute / respond.
// Depends on ole_pkg.
`default_nettype none

module ole_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output ole_pkg::dp_cmd_t     dp_cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o    = (state_q == S_IDLE) || ((state_q == S_RESP) && out_ready_i);
  assign out_valid_o   = out_valid_q;
  assign dp_cmd_o.load = in_valid_i && in_ready_o;
  assign dp_cmd_o.exec = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= in_valid_i ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ole_datapath.sv
// Entry cell chain, count, match search and result registers of the
// ordered list engine. Depends on ole_pkg.
`default_nettype none

module ole_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ole_pkg::dp_cmd_t                dp_cmd_i,
  input  wire logic [ole_pkg::CmdW-1:0]        cmd_i,
  input  wire logic [ole_pkg::PosW-1:0]        position_i,
  input  wire logic signed [ole_pkg::DataW-1:0] item_value_i,
  output logic [ole_pkg::StatW-1:0]            status_o,
  output logic [ole_pkg::FoundW-1:0]           found_position_o,
  output logic [ole_pkg::CntW-1:0]             entry_count_o
);

  localparam int Cap = ole_pkg::Capacity;

  // captured command
  ole_pkg::cmd_e                cmd_q;
  logic [ole_pkg::PosW-1:0]     pos_q;
  logic [ole_pkg::DataW-1:0]    val_q;

  logic [ole_pkg::DataW-1:0]    entries_q [Cap];
  logic [ole_pkg::CntW-1:0]     count_q, count_d;

  ole_pkg::status_e             status_q, status_d;
  logic [ole_pkg::FoundW-1:0]   found_q, found_d;

  logic                         full, empty;
  logic                         do_ins, do_del;
  logic [ole_pkg::CntW-1:0]     op_pos;
  logic [Cap-1:0]               match;
  logic                         hit;
  logic [ole_pkg::IdxW-1:0]     hit_idx;

  assign full  = (count_q == ole_pkg::CntW'(Cap));
  assign empty = (count_q == '0);

  always_comb begin
    match   = '0;
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < Cap; i++) begin
      match[i] = (ole_pkg::CntW'(i) < count_q) && (entries_q[i] == val_q);
    end
    // lowest matching index wins
    for (int i = Cap - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = ole_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    status_d = ole_pkg::ST_OK;
    found_d  = '0;
    count_d  = count_q;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    op_pos   = '0;
    case (cmd_q)
      ole_pkg::CMD_ADD_TAIL, ole_pkg::CMD_ADD_HEAD: begin
        if (full) begin
          status_d = ole_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          op_pos  = (cmd_q == ole_pkg::CMD_ADD_TAIL) ? count_q : '0;
          count_d = count_q + ole_pkg::CntW'(1);
        end
      end
      ole_pkg::CMD_INSERT_AT: begin
        if (pos_q > count_q) begin
          status_d = ole_pkg::ST_BAD_INDEX;
        end else if (full) begin
          status_d = ole_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          op_pos  = pos_q;
          count_d = count_q + ole_pkg::CntW'(1);
        end
      end
      ole_pkg::CMD_REMOVE_TAIL, ole_pkg::CMD_REMOVE_HEAD: begin
        if (empty) begin
          status_d = ole_pkg::ST_EMPTY;
        end else begin
          do_del  = 1'b1;
          op_pos  = (cmd_q == ole_pkg::CMD_REMOVE_TAIL) ? count_q - ole_pkg::CntW'(1) : '0;
          count_d = count_q - ole_pkg::CntW'(1);
        end
      end
      ole_pkg::CMD_REMOVE_AT: begin
        if (pos_q >= count_q) begin
          status_d = ole_pkg::ST_BAD_INDEX;
        end else begin
          do_del  = 1'b1;
          op_pos  = pos_q;
          count_d = count_q - ole_pkg::CntW'(1);
        end
      end
      ole_pkg::CMD_FIND: begin
        if (empty) begin
          status_d = ole_pkg::ST_EMPTY;
        end else if (hit) begin
          found_d = ole_pkg::FoundW'(hit_idx);
        end else begin
          status_d = ole_pkg::ST_NOT_FOUND;
        end
      end
      ole_pkg::CMD_CLEAR: begin
        if (empty) status_d = ole_pkg::ST_EMPTY;
        else       count_d  = '0;
      end
      default: status_d = ole_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      cmd_q <= ole_pkg::cmd_e'(cmd_i);
      pos_q <= position_i;
      val_q <= item_value_i;
    end
  end

  // each cell looks only at its neighbors
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec) begin
      for (int i = 0; i < Cap; i++) begin
        if (do_ins) begin
          if (ole_pkg::CntW'(i) == op_pos) begin
            entries_q[i] <= val_q;
          end else if ((i > 0) && (ole_pkg::CntW'(i) > op_pos)) begin
            entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
          end
        end else if (do_del) begin
          if ((i < Cap - 1) && (ole_pkg::CntW'(i) >= op_pos)) begin
            entries_q[i] <= entries_q[(i < Cap - 1) ? i + 1 : i];
          end
        end
      end
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (dp_cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign entry_count_o    = count_q;

endmodule

`default_nettype wire

FILE: rtl/ordered_list_engine.sv
// Top level of the ordered list engine: controller plus datapath.
// Depends on ole_pkg, ole_ctrl, ole_datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o | cmd_i, position_i, item_value_i
//  out     | out_valid_o / out_ready_i | status_o, found_position_o, entry_count_o
//
// Each command is captured on its beat, then executed in the execute state, in which
// all 16 cells shift and compare in parallel; the result is valid the cycle
// after. A new beat is taken in the same cycle the result beat leaves.
// Reset clears the count and control only; entries hold until written.
// A stalled result blocks new input.
`default_nettype none

module ordered_list_engine (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [ole_pkg::CmdW-1:0]         cmd_i,
  input  wire logic [ole_pkg::PosW-1:0]         position_i,
  input  wire logic signed [ole_pkg::DataW-1:0] item_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [ole_pkg::StatW-1:0]             status_o,
  output logic [ole_pkg::FoundW-1:0]            found_position_o,
  output logic [ole_pkg::CntW-1:0]              entry_count_o
);

  ole_pkg::dp_cmd_t dp_cmd;

  ole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd)
  );

  ole_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= ole_pkg::CntW'(ole_pkg::Capacity)))
    else $error("entry count above capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (found_position_o != '0)) |-> (status_o == ole_pkg::ST_OK))
    else $error("found position set on failed command");

  a_exec_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!out_valid_o && !in_ready_o))
    else $error("accepted beat did not enter execute");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && in_valid_i) |=> ##1
      ((status_o == ole_pkg::ST_OK) || (entry_count_o == $past(entry_count_o, 2))))
    else $error("failed command changed the count");

endmodule

`default_nettype wire
